// File: rtl/mpfp_pkg.sv
`timescale 1ns / 1ps
package mpfp_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_LENGTH_BYTES   = 4;
  localparam int DEF_BUFFER_LENGTH_BITS = 16;

  // Fixed widths of the stored fields.
  localparam int LEN_MAX_W = 16;   // widest buffer length count
  localparam int HDR_END_W = 3;    // header end index, at most five
  localparam int SUM_W     = 28;   // remaining length, four groups of seven bits
  localparam int TOTAL_W   = 29;   // remaining length plus header bytes
  localparam int EXT_W     = 18;   // room for header end + 2 + topic length + 2

  localparam int QUEUE_DEPTH = 2;

  // MQTT control packet types.
  localparam logic [3:0] TYPE_PUBLISH  = 4'd3;
  localparam logic [3:0] TYPE_PUBACK   = 4'd4;
  localparam logic [3:0] TYPE_PUBREC   = 4'd5;
  localparam logic [3:0] TYPE_PUBREL   = 4'd6;
  localparam logic [3:0] TYPE_PUBCOMP  = 4'd7;
  localparam logic [3:0] TYPE_SUBSCRIBE = 4'd8;
  localparam logic [3:0] TYPE_SUBACK   = 4'd9;
  localparam logic [3:0] TYPE_UNSUBACK = 4'd11;

  // Everything the front end learned about one buffer.
  typedef struct packed {
    logic [7:0]           head_byte;
    logic [SUM_W-1:0]     remaining_sum;
    logic                 length_done;
    logic [HDR_END_W-1:0] header_end;
    logic                 second_continues;
    logic                 overlong;
    logic [15:0]          topic_size;
    logic [15:0]          early_id;
    logic [15:0]          publish_id;
    logic [LEN_MAX_W-1:0] len;
  } snap_t;

endpackage

// File: rtl/mpfp_front.sv
`timescale 1ns / 1ps
module mpfp_front #(
  parameter int MAX_LENGTH_BYTES   = mpfp_pkg::DEF_MAX_LENGTH_BYTES,
  parameter int BUFFER_LENGTH_BITS = mpfp_pkg::DEF_BUFFER_LENGTH_BITS
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_data_byte,
  input  logic            in_last_byte,
  output logic            push_valid,
  input  logic            push_stall,
  output mpfp_pkg::snap_t push_data
);
  import mpfp_pkg::*;

  localparam int LW = BUFFER_LENGTH_BITS;
  localparam logic [LW-1:0] COUNT_MAX = '1;

  logic [LW-1:0]        count_r, count_nxt;
  logic [7:0]           head_r, head_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 done_r, done_nxt;
  logic [HDR_END_W-1:0] hend_r, hend_nxt;
  logic                 sc_r, sc_nxt;
  logic [15:0]          topic_r, topic_nxt;
  logic [15:0]          early_r, early_nxt;
  logic [15:0]          pid_r, pid_nxt;
  logic                 ovl_r, ovl_nxt;

  logic [EXT_W-1:0] p_ext, hend_ext, id_pos;
  logic             accept;

  assign in_stall   = push_stall;
  assign push_valid = in_valid & in_last_byte;
  assign accept     = in_valid & ~push_stall;

  assign p_ext    = EXT_W'(count_r);
  assign hend_ext = EXT_W'(hend_r);
  assign id_pos   = hend_ext + EXT_W'(2) + EXT_W'(topic_r);

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    sum_nxt   = sum_r;
    done_nxt  = done_r;
    hend_nxt  = hend_r;
    sc_nxt    = sc_r;
    topic_nxt = topic_r;
    early_nxt = early_r;
    pid_nxt   = pid_r;
    ovl_nxt   = ovl_r;
    // Once the count saturates, further bytes are dropped.
    if (count_r != COUNT_MAX) begin
      if (count_r == LW'(0)) head_nxt = in_data_byte;
      if (count_r == LW'(1)) sc_nxt = in_data_byte[7];
      if (count_r == LW'(2)) early_nxt[15:8] = in_data_byte;
      if (count_r == LW'(3)) early_nxt[7:0] = in_data_byte;
      if (done_r && !ovl_r) begin
        if (p_ext == hend_ext) begin
          topic_nxt[15:8] = in_data_byte;
        end else if (p_ext == hend_ext + EXT_W'(1)) begin
          topic_nxt[7:0] = in_data_byte;
        end else if (p_ext == id_pos) begin
          pid_nxt[15:8] = in_data_byte;
        end else if (p_ext == id_pos + EXT_W'(1)) begin
          pid_nxt[7:0] = in_data_byte;
        end
      end else if (count_r != LW'(0) && !done_r && count_r <= LW'(MAX_LENGTH_BYTES)) begin
        for (int k = 1; k <= MAX_LENGTH_BYTES; k++) begin
          if (count_r == LW'(k)) begin
            sum_nxt[7*(k-1) +: 7] = sum_r[7*(k-1) +: 7] | in_data_byte[6:0];
          end
        end
        if (!in_data_byte[7]) begin
          done_nxt = 1'b1;
          hend_nxt = count_r[HDR_END_W-1:0] + HDR_END_W'(1);
        end else if (count_r == LW'(MAX_LENGTH_BYTES)) begin
          done_nxt = 1'b1;
          ovl_nxt  = 1'b1;
          hend_nxt = HDR_END_W'(MAX_LENGTH_BYTES + 1);
        end
      end
      count_nxt = count_r + LW'(1);
    end
  end

  always_comb begin
    push_data.head_byte        = head_nxt;
    push_data.remaining_sum    = sum_nxt;
    push_data.length_done      = done_nxt;
    push_data.header_end       = hend_nxt;
    push_data.second_continues = sc_nxt;
    push_data.overlong         = ovl_nxt;
    push_data.topic_size       = topic_nxt;
    push_data.early_id         = early_nxt;
    push_data.publish_id       = pid_nxt;
    push_data.len              = LEN_MAX_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    // The final byte hands its record to the queue and clears the state.
    if (!rst_n || (accept && in_last_byte)) begin
      count_r <= '0;
      head_r  <= '0;
      sum_r   <= '0;
      done_r  <= 1'b0;
      hend_r  <= '0;
      sc_r    <= 1'b0;
      topic_r <= '0;
      early_r <= '0;
      pid_r   <= '0;
      ovl_r   <= 1'b0;
    end else if (accept) begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      sum_r   <= sum_nxt;
      done_r  <= done_nxt;
      hend_r  <= hend_nxt;
      sc_r    <= sc_nxt;
      topic_r <= topic_nxt;
      early_r <= early_nxt;
      pid_r   <= pid_nxt;
      ovl_r   <= ovl_nxt;
    end
  end

endmodule

// File: rtl/mpfp_queue.sv
`timescale 1ns / 1ps
module mpfp_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_stall,
  input  mpfp_pkg::snap_t wr_data,
  output logic            rd_valid,
  input  logic            rd_stall,
  output mpfp_pkg::snap_t rd_data
);
  import mpfp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  snap_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             wr_en, rd_en;

  assign wr_stall = (count_r == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = entry_r[rd_ptr_r];
  assign wr_en    = wr_valid & ~wr_stall;
  assign rd_en    = rd_valid & ~rd_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_r[wr_ptr_r] <= wr_data;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue holds more records than its depth");
  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !rd_en) |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue count missed a write");
  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && !wr_en) |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("queue count missed a read");
`endif

endmodule

// File: rtl/mpfp_back.sv
`timescale 1ns / 1ps
module mpfp_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           pop_valid,
  output logic                           pop_stall,
  input  mpfp_pkg::snap_t                pop_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [3:0]                     out_packet_type,
  output logic [1:0]                     out_qos_level,
  output logic [mpfp_pkg::TOTAL_W-1:0]   out_total_length,
  output logic [15:0]                    out_topic_offset,
  output logic [15:0]                    out_topic_length,
  output logic                           out_topic_ok,
  output logic [15:0]                    out_payload_offset,
  output logic [15:0]                    out_payload_length,
  output logic                           out_payload_ok,
  output logic [15:0]                    out_packet_id,
  output logic                           out_length_error
);
  import mpfp_pkg::*;

  typedef struct packed {
    logic [3:0]           ptype;
    logic [1:0]           qos;
    logic                 err;
    logic [TOTAL_W-1:0]   total;
    logic [EXT_W-1:0]     tstart;
    logic [EXT_W-1:0]     tend;
    logic [15:0]          topic_size;
    logic                 base;
    logic                 tend_le;
    logic                 tend_lt;
    logic                 tend2_lt;
    logic [LEN_MAX_W-1:0] len;
    logic                 early_ok;
    logic [15:0]          early_id;
    logic [15:0]          publish_id;
  } stage_t;

  stage_t s1_r, s1_nxt;
  logic   s1_valid_r, out_valid_r;
  logic   out_adv, s1_adv;

  logic [EXT_W-1:0] len_ext, h_ext;

  assign out_adv   = ~out_valid_r | ~out_stall;
  assign s1_adv    = ~s1_valid_r | out_adv;
  assign pop_stall = ~s1_adv;
  assign out_valid = out_valid_r;

  // First stage: header end, total length and the topic end compares.
  always_comb begin
    len_ext = EXT_W'(pop_data.len);
    h_ext   = pop_data.length_done ? EXT_W'(pop_data.header_end) : len_ext;
    s1_nxt.ptype      = pop_data.head_byte[7:4];
    s1_nxt.qos        = pop_data.head_byte[2:1];
    s1_nxt.err        = pop_data.overlong;
    s1_nxt.total      = TOTAL_W'(pop_data.remaining_sum) + TOTAL_W'(h_ext);
    s1_nxt.tstart     = h_ext + EXT_W'(2);
    s1_nxt.tend       = h_ext + EXT_W'(2) + EXT_W'(pop_data.topic_size);
    s1_nxt.topic_size = pop_data.topic_size;
    s1_nxt.base       = !pop_data.overlong && pop_data.length_done &&
                        (s1_nxt.tstart < len_ext);
    s1_nxt.tend_le    = (s1_nxt.tend <= len_ext);
    s1_nxt.tend_lt    = (s1_nxt.tend < len_ext);
    s1_nxt.tend2_lt   = (s1_nxt.tend + EXT_W'(2) < len_ext);
    s1_nxt.len        = pop_data.len;
    s1_nxt.early_ok   = (pop_data.len >= LEN_MAX_W'(4)) && !pop_data.second_continues;
    s1_nxt.early_id   = pop_data.early_id;
    s1_nxt.publish_id = pop_data.publish_id;
  end

  // Second stage: payload bounds and packet identifier.
  logic [TOTAL_W-1:0] pi, len_t, plen;
  logic               t_ok, p_ok, id_ok;
  logic [15:0]        id;

  always_comb begin
    len_t = TOTAL_W'(s1_r.len);
    pi    = (s1_r.qos != 2'd0) ? TOTAL_W'(s1_r.tend) + TOTAL_W'(2) : TOTAL_W'(s1_r.tend);
    t_ok  = s1_r.base && s1_r.tend_le;
    id_ok = s1_r.base && s1_r.tend_lt && (s1_r.qos != 2'd0) && s1_r.tend2_lt;
    p_ok  = s1_r.base && s1_r.tend_lt && ((s1_r.qos == 2'd0) || s1_r.tend2_lt) &&
            (s1_r.total >= pi);
    plen  = (s1_r.total <= len_t) ? (s1_r.total - pi) : (len_t - pi);
    unique case (s1_r.ptype) inside
      TYPE_PUBLISH: id = id_ok ? s1_r.publish_id : 16'd0;
      TYPE_PUBACK, TYPE_PUBREC, TYPE_PUBREL, TYPE_PUBCOMP,
      TYPE_SUBSCRIBE, TYPE_SUBACK, TYPE_UNSUBACK:
        id = s1_r.early_ok ? s1_r.early_id : 16'd0;
      default: id = 16'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_r <= pop_valid;
      if (out_adv) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && pop_valid) begin
      s1_r <= s1_nxt;
    end
    if (out_adv && s1_valid_r) begin
      out_packet_type    <= s1_r.ptype;
      out_qos_level      <= s1_r.qos;
      out_total_length   <= s1_r.total;
      out_topic_offset   <= t_ok ? s1_r.tstart[15:0] : 16'd0;
      out_topic_length   <= t_ok ? s1_r.topic_size : 16'd0;
      out_topic_ok       <= t_ok;
      out_payload_offset <= p_ok ? pi[15:0] : 16'd0;
      out_payload_length <= p_ok ? plen[15:0] : 16'd0;
      out_payload_ok     <= p_ok;
      out_packet_id      <= id;
      out_length_error   <= s1_r.err;
    end
  end

endmodule

// File: rtl/mqtt_packet_field_parser.sv
`timescale 1ns / 1ps
// Accepts one packet byte per cycle unless the queue is full; each packet's record passes
// through the queue, the first stage register and the output registers to the result.
// Throughput is one byte per cycle unless stalled, set by the front end's per-byte capture.
// A two-record queue lets the front end run on while the result stage is stalled.
// Reset is synchronous and active low; it clears all parse state, the queue and the
// result valid flags, and the block is ready in the first cycle after reset.
module mqtt_packet_field_parser #(
  parameter int MAX_LENGTH_BYTES   = mpfp_pkg::DEF_MAX_LENGTH_BYTES,
  parameter int BUFFER_LENGTH_BITS = mpfp_pkg::DEF_BUFFER_LENGTH_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_data_byte,
  input  logic                         in_last_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [3:0]                   out_packet_type,
  output logic [1:0]                   out_qos_level,
  output logic [mpfp_pkg::TOTAL_W-1:0] out_total_length,
  output logic [15:0]                  out_topic_offset,
  output logic [15:0]                  out_topic_length,
  output logic                         out_topic_ok,
  output logic [15:0]                  out_payload_offset,
  output logic [15:0]                  out_payload_length,
  output logic                         out_payload_ok,
  output logic [15:0]                  out_packet_id,
  output logic                         out_length_error
);
  import mpfp_pkg::*;

  logic  push_valid, push_stall;
  snap_t push_data;
  logic  pop_valid, pop_stall;
  snap_t pop_data;

  mpfp_front #(
    .MAX_LENGTH_BYTES   (MAX_LENGTH_BYTES),
    .BUFFER_LENGTH_BITS (BUFFER_LENGTH_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .push_valid   (push_valid),
    .push_stall   (push_stall),
    .push_data    (push_data)
  );

  mpfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_stall (push_stall),
    .wr_data  (push_data),
    .rd_valid (pop_valid),
    .rd_stall (pop_stall),
    .rd_data  (pop_data)
  );

  mpfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .pop_valid          (pop_valid),
    .pop_stall          (pop_stall),
    .pop_data           (pop_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_packet_type    (out_packet_type),
    .out_qos_level      (out_qos_level),
    .out_total_length   (out_total_length),
    .out_topic_offset   (out_topic_offset),
    .out_topic_length   (out_topic_length),
    .out_topic_ok       (out_topic_ok),
    .out_payload_offset (out_payload_offset),
    .out_payload_length (out_payload_length),
    .out_payload_ok     (out_payload_ok),
    .out_packet_id      (out_packet_id),
    .out_length_error   (out_length_error)
  );

endmodule
